[sv/rbrm_pkg.sv]
// Shared types and constants of the receive buffer ring manager.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package rbrm_pkg;

   localparam int RING_SLOTS = 64;
   localparam int IDX_W = $clog2(RING_SLOTS);
   localparam int PTR_W = IDX_W + 1;
   localparam int STAMP_W = 32;
   localparam int COUNT_W = 7;
   localparam logic [STAMP_W-1:0] TIMEOUT_RESET = 32'd250;

   typedef enum logic [1:0] {
      SLOT_FREE    = 2'd0,
      SLOT_PENDING = 2'd1,
      SLOT_READY   = 2'd2,
      SLOT_IN_USE  = 2'd3
   } slot_state_type;

   typedef enum logic [2:0] {
      RSP_OK          = 3'd0,
      RSP_FULL        = 3'd1,
      RSP_BUSY        = 3'd2,
      RSP_EMPTY       = 3'd3,
      RSP_BAD_INDEX   = 3'd4,
      RSP_WRONG_STATE = 3'd5
   } rsp_code_type;

   typedef enum logic [2:0] {
      MODE_CLAIM    = 3'd0,
      MODE_COMPLETE = 3'd1,
      MODE_TAKE     = 3'd2,
      MODE_RELEASE  = 3'd3,
      MODE_SWEEP    = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLAIM_SKIP,
      ST_CLAIM_HEAD,
      ST_TAKE,
      ST_RELEASE,
      ST_SWEEP_ADD,
      ST_SWEEP_SUB,
      ST_DONE
   } fsm_state_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      slot_state_type   data;
   } slot_wr_type;

   typedef struct packed {
      logic               en;
      logic [IDX_W-1:0]   addr;
      logic [STAMP_W-1:0] data;
   } stamp_wr_type;

endpackage

`default_nettype wire

[sv/rbrm_alu.sv]
// Shared 32-bit add/subtract unit of the ring manager's sequencer.
// Depends on rbrm_pkg.
`default_nettype none

module rbrm_alu
   import rbrm_pkg::*;
(
   input  wire alu_op_type         op,
   input  wire logic [STAMP_W-1:0] a,
   input  wire logic [STAMP_W-1:0] b,
   output logic      [STAMP_W-1:0] y
);

   always_comb begin
      unique case (op)
         ALU_ADD: y = a + b;
         ALU_SUB: y = a - b;
      endcase
   end

endmodule

`default_nettype wire

[sv/rbrm_status_mem.sv]
// Slot state memory with one valid bit per entry; an entry never written
// since reset reads as free. Depends on rbrm_pkg.
`default_nettype none

module rbrm_status_mem
   import rbrm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire slot_wr_type      wr,
   input  wire logic [IDX_W-1:0] rd_addr,
   output slot_state_type        rd_data
);

   slot_state_type          mem [RING_SLOTS];
   logic [RING_SLOTS-1:0]   valid_ff;
   slot_state_type          rd_data_ff;
   logic                    rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr] & ~reset;
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : SLOT_FREE;

endmodule

`default_nettype wire

[sv/rbrm_stamp_mem.sv]
// Claim time stamp memory, one write and one registered read per cycle.
// Depends on rbrm_pkg.
`default_nettype none

module rbrm_stamp_mem
   import rbrm_pkg::*;
(
   input  wire logic               clock,
   input  wire stamp_wr_type       wr,
   input  wire logic [IDX_W-1:0]   rd_addr,
   output logic      [STAMP_W-1:0] rd_data
);

   logic [STAMP_W-1:0] mem [RING_SLOTS];
   logic [STAMP_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/rx_buffer_ring_manager.sv]
// Receive buffer ring manager: one item at a time; busy is high from accept to result.
// A claim on a full ring first skips free tail slots; a take examines slots from the tail until
// it finds a ready one or the ring runs empty; a sweep visits every slot, with an extra step
// for each live slot. The strobe cannot be stalled; a new item is accepted in the cycle after
// it, so no new item is taken until the last one is done. Reset is synchronous: all slots
// free, pointers zero.
`default_nettype none

module rx_buffer_ring_manager
   import rbrm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // Command side
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [2:0]         req_mode,
   input  wire logic [IDX_W-1:0]   req_slot_index,
   input  wire logic [STAMP_W-1:0] req_now_time,
   // Result side
   output logic                    rsp_strobe,
   output logic      [2:0]         rsp_status,
   output logic      [IDX_W-1:0]   rsp_slot_out,
   output logic      [COUNT_W-1:0] rsp_reclaimed_count,
   // Timeout register write
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [STAMP_W-1:0] csr_timeout_ticks
);

   // Control state.
   fsm_state_type      state_ff, state_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [STAMP_W-1:0] timeout_ff;

   // Per-item working registers.
   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic [STAMP_W-1:0] now_ff, now_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [STAMP_W-1:0] sum_ff, sum_in;
   rsp_code_type       status_ff, status_in;
   logic [IDX_W-1:0]   out_slot_ff, out_slot_in;
   logic [COUNT_W-1:0] recl_ff, recl_in;

   // Memory and shared unit connections.
   slot_wr_type        st_wr;
   stamp_wr_type       sp_wr;
   logic [IDX_W-1:0]   rd_addr;
   slot_state_type     st_rd;
   logic [STAMP_W-1:0] sp_rd;
   alu_op_type         alu_op;
   logic [STAMP_W-1:0] alu_a, alu_b, alu_y;

   // Ring occupancy: the pointers run modulo twice the ring size, which the
   // natural wrap of PTR_W bits gives.
   logic [PTR_W-1:0]   count;
   logic               full;
   logic               bad_index;
   logic               last_slot;
   logic [IDX_W-1:0]   head_slot, tail_slot;

   assign count     = head_ff - tail_ff;
   assign full      = (count >= PTR_W'(RING_SLOTS - 1));
   assign bad_index = ({1'b0, req_slot_index} >= PTR_W'(RING_SLOTS));
   assign last_slot = (idx_ff == IDX_W'(RING_SLOTS - 1));
   assign head_slot = head_ff[IDX_W-1:0];
   assign tail_slot = tail_ff[IDX_W-1:0];

   rbrm_status_mem u_status_mem (
      .clock   (clock),
      .reset   (reset),
      .wr      (st_wr),
      .rd_addr (rd_addr),
      .rd_data (st_rd)
   );

   rbrm_stamp_mem u_stamp_mem (
      .clock   (clock),
      .wr      (sp_wr),
      .rd_addr (rd_addr),
      .rd_data (sp_rd)
   );

   rbrm_alu u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .y  (alu_y)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         head_ff    <= '0;
         tail_ff    <= '0;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         if (csr_valid && csr_ready) begin
            timeout_ff <= csr_timeout_ticks;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      now_ff      <= now_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      sum_ff      <= sum_in;
      status_ff   <= status_in;
      out_slot_ff <= out_slot_in;
      recl_ff     <= recl_in;
   end

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      slot_in     = slot_ff;
      now_in      = now_ff;
      idx_in      = idx_ff;
      cnt_in      = cnt_ff;
      sum_in      = sum_ff;
      status_in   = status_ff;
      out_slot_in = out_slot_ff;
      recl_in     = recl_ff;
      rd_addr     = tail_slot;
      st_wr       = '0;
      sp_wr       = '0;
      alu_op      = ALU_ADD;
      alu_a       = sp_rd;
      alu_b       = timeout_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               slot_in     = req_slot_index;
               now_in      = req_now_time;
               status_in   = RSP_OK;
               out_slot_in = '0;
               recl_in     = '0;
               unique case (req_mode)
                  MODE_CLAIM: begin
                     // A full ring first tries to drop freed slots at the tail.
                     if (full) begin
                        rd_addr  = tail_slot;
                        state_in = ST_CLAIM_SKIP;
                     end else begin
                        rd_addr  = head_slot;
                        state_in = ST_CLAIM_HEAD;
                     end
                  end
                  MODE_COMPLETE: begin
                     if (bad_index) begin
                        status_in = RSP_BAD_INDEX;
                     end else begin
                        st_wr = '{en: 1'b1, addr: req_slot_index, data: SLOT_READY};
                     end
                     state_in = ST_DONE;
                  end
                  MODE_TAKE: begin
                     if (count == '0) begin
                        status_in = RSP_EMPTY;
                        state_in  = ST_DONE;
                     end else begin
                        rd_addr  = tail_slot;
                        state_in = ST_TAKE;
                     end
                  end
                  MODE_RELEASE: begin
                     if (bad_index) begin
                        status_in = RSP_BAD_INDEX;
                        state_in  = ST_DONE;
                     end else begin
                        rd_addr  = req_slot_index;
                        state_in = ST_RELEASE;
                     end
                  end
                  MODE_SWEEP: begin
                     idx_in   = '0;
                     cnt_in   = '0;
                     rd_addr  = '0;
                     state_in = ST_SWEEP_ADD;
                  end
                  default: begin
                     status_in = RSP_WRONG_STATE;
                     state_in  = ST_DONE;
                  end
               endcase
            end
         end

         ST_CLAIM_SKIP: begin
            // The read of the next tail slot is issued while this one is checked.
            if (count != '0 && st_rd == SLOT_FREE) begin
               tail_in = tail_ff + PTR_W'(1);
               rd_addr = tail_in[IDX_W-1:0];
            end else if (full) begin
               status_in = RSP_FULL;
               state_in  = ST_DONE;
            end else begin
               rd_addr  = head_slot;
               state_in = ST_CLAIM_HEAD;
            end
         end

         ST_CLAIM_HEAD: begin
            if (st_rd != SLOT_FREE) begin
               status_in = RSP_BUSY;
            end else begin
               st_wr       = '{en: 1'b1, addr: head_slot, data: SLOT_PENDING};
               sp_wr       = '{en: 1'b1, addr: head_slot, data: now_ff};
               head_in     = head_ff + PTR_W'(1);
               out_slot_in = head_slot;
            end
            state_in = ST_DONE;
         end

         ST_TAKE: begin
            // Every examined slot is passed by the tail, found or not.
            tail_in = tail_ff + PTR_W'(1);
            if (st_rd == SLOT_READY) begin
               st_wr       = '{en: 1'b1, addr: tail_slot, data: SLOT_IN_USE};
               out_slot_in = tail_slot;
               state_in    = ST_DONE;
            end else if (count == PTR_W'(1)) begin
               status_in = RSP_EMPTY;
               state_in  = ST_DONE;
            end else begin
               rd_addr = tail_in[IDX_W-1:0];
            end
         end

         ST_RELEASE: begin
            if (st_rd == SLOT_IN_USE) begin
               st_wr = '{en: 1'b1, addr: slot_ff, data: SLOT_FREE};
            end else begin
               status_in = RSP_WRONG_STATE;
            end
            state_in = ST_DONE;
         end

         ST_SWEEP_ADD: begin
            // Live slots get their deadline, stamp plus timeout, from the shared unit.
            if (st_rd == SLOT_PENDING || st_rd == SLOT_READY) begin
               alu_op   = ALU_ADD;
               alu_a    = sp_rd;
               alu_b    = timeout_ff;
               sum_in   = alu_y;
               state_in = ST_SWEEP_SUB;
            end else if (last_slot) begin
               recl_in  = cnt_ff;
               state_in = ST_DONE;
            end else begin
               idx_in  = idx_ff + IDX_W'(1);
               rd_addr = idx_in;
            end
         end

         ST_SWEEP_SUB: begin
            // Expired when the time is strictly after the deadline, modulo 2^32.
            alu_op = ALU_SUB;
            alu_a  = now_ff;
            alu_b  = sum_ff;
            if (alu_y != '0 && !alu_y[STAMP_W-1]) begin
               st_wr = '{en: 1'b1, addr: idx_ff, data: SLOT_FREE};
               if (cnt_ff != '1) begin
                  cnt_in = cnt_ff + COUNT_W'(1);
               end
            end
            if (last_slot) begin
               recl_in  = cnt_in;
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               rd_addr  = idx_in;
               state_in = ST_SWEEP_ADD;
            end
         end

         ST_DONE: begin
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy                = (state_ff != ST_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_strobe          = (state_ff == ST_DONE);
   assign rsp_status          = status_ff;
   assign rsp_slot_out        = out_slot_ff;
   assign rsp_reclaimed_count = recl_ff;

endmodule

`default_nettype wire
